// ===== sv/sem_pkg.sv =====
// Shared types, constants and codes for the RGB Sobel edge magnitude block.
`default_nettype none
package sem_pkg;
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int ROW_BITS     = 13;
   localparam int WIDTH_BITS   = 11;
   localparam int HEIGHT_BITS  = 13;
   localparam int SQ_BITS      = 21;
   localparam int GRAD_BITS    = 11;
   localparam int ROOT_STEPS   = 8;
   localparam int ROOT_LIMIT   = 65280;
   localparam int CLAMP_LEVEL  = 255;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;

   typedef logic [23:0] pixel_type;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_ROOT
   } state_type;

   typedef struct packed {
      logic start;
      logic [SQ_BITS-1:0] square;
   } root_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [7:0] root;
   } root_rsp_type;
endpackage
`default_nettype wire

// ===== sv/sem_root.sv =====
// Iterative rounded integer square root with clamp to 255.
`default_nettype none
module sem_root
   import sem_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire root_req_type req,
   output root_rsp_type      rsp
);
   logic [SQ_BITS-1:0] s_ff;
   logic [8:0]         f_ff, f_in;
   logic [3:0]         step_ff;
   logic               busy_ff, done_ff;
   logic [7:0]         bit_v, trial;
   logic [15:0]        trial_sq;
   logic [17:0]        f_sq_f;

   always_comb begin
      bit_v    = 8'h80 >> step_ff[2:0];
      trial    = f_ff[7:0] | bit_v;
      trial_sq = trial * trial;
      f_sq_f   = 18'(f_ff[7:0] * f_ff[7:0]) + 18'(f_ff[7:0]);
      f_in     = f_ff;
      if (step_ff < 4'(ROOT_STEPS)) begin
         if (SQ_BITS'(trial_sq) <= s_ff) begin
            f_in = {1'b0, trial};
         end
      end else if (s_ff > SQ_BITS'(ROOT_LIMIT)) begin
         f_in = 9'(CLAMP_LEVEL);
      end else if (SQ_BITS'(f_sq_f) < s_ff) begin
         f_in = (f_ff[7:0] == 8'(CLAMP_LEVEL)) ? f_ff : f_ff + 9'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 4'd1;
         if (step_ff == 4'(ROOT_STEPS)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         s_ff <= req.square;
         f_ff <= '0;
      end else if (busy_ff) begin
         f_ff <= f_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.root = f_ff[7:0];

   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      req.start |=> !done_ff && busy_ff) else $error("root start did not begin");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && busy_ff)) else $error("root done while busy");
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && step_ff == 4'(ROOT_STEPS) && !req.start) |=> done_ff)
      else $error("root did not finish");
endmodule
`default_nettype wire

// ===== sv/sobel_edge_magnitude_rgb.sv =====
// Streaming 3x3 Sobel edge magnitude on RGB pixels with line store and window.
// A pixel beat is taken in the idle state; its row-above entries are read from a
// 1024-deep line store (registered read) and written back the next cycle. A beat
// that yields no result goes from idle to read and back to idle; one that yields
// a result then passes square, 9 bit-serial square root steps and a handoff that
// waits for a free result register, which lets the next beat enter while a result
// waits. Results lag input by one row and one pixel; send width+1 flush beats
// (tuser high) after a frame. Line store contents are undefined after reset.
`default_nettype none
module sobel_edge_magnitude_rgb
   import sem_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [23:0]            req_tdata,  // red_in, green_in, blue_in
   input  wire logic                   req_tuser,  // action
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [23:0]                 rsp_tdata,  // red_out, green_out, blue_out
   output logic                        rsp_tlast,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_index,
   input  wire logic [HEIGHT_BITS-1:0] csr_data
);
   state_type               state_ff, state_in;
   logic [COL_BITS-1:0]     col_ff, c_ff, c_acc;
   logic [ROW_BITS-1:0]     row_ff, r_ff, r_acc;
   logic [WIDTH_BITS-1:0]   width_ff, w_eff;
   logic [HEIGHT_BITS-1:0]  height_ff, h_eff;
   logic [WIDTH_BITS-1:0]   c_next;
   pixel_type               v_ff, v_acc, top, mid;
   logic [47:0]             line_mem [MAX_WIDTH];
   logic [47:0]             rd_ff;
   pixel_type               win_ff [9];
   pixel_type               base [9];
   pixel_type               nwin [9];
   pixel_type               ewin [9];
   logic                    emit, last;
   logic                    accept, out_free;
   logic signed [GRAD_BITS-1:0] gx_ff [3];
   logic signed [GRAD_BITS-1:0] gy_ff [3];
   logic signed [GRAD_BITS-1:0] gx_in [3];
   logic signed [GRAD_BITS-1:0] gy_in [3];
   logic                    last_ff;
   root_req_type            rreq [3];
   root_rsp_type            rrsp [3];
   logic                    rsp_tvalid_ff, rsp_tlast_ff;
   logic [23:0]             rsp_tdata_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(RESET_WIDTH);
         height_ff <= HEIGHT_BITS'(RESET_HEIGHT);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign w_eff = (width_ff == '0) ? WIDTH_BITS'(1) :
                  (width_ff > WIDTH_BITS'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? HEIGHT_BITS'(1) :
                  (height_ff > HEIGHT_BITS'(MAX_HEIGHT)) ? HEIGHT_BITS'(MAX_HEIGHT)
                                                         : height_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      if ({1'b0, col_ff} >= w_eff) begin
         c_acc = '0;
         r_acc = row_ff + ROW_BITS'(1);
      end else begin
         c_acc = col_ff;
         r_acc = row_ff;
      end
      v_acc = (req_tuser || r_acc >= h_eff) ? '0
            : {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      c_next = WIDTH_BITS'(c_acc) + WIDTH_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (c_acc == '0 && r_acc > h_eff) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (c_next >= w_eff) begin
            col_ff <= '0;
            row_ff <= r_acc + ROW_BITS'(1);
         end else begin
            col_ff <= c_next[COL_BITS-1:0];
            row_ff <= r_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff  <= c_acc;
         r_ff  <= r_acc;
         v_ff  <= v_acc;
         rd_ff <= line_mem[c_acc];
      end
      if (state_ff == ST_READ) begin
         line_mem[c_ff] <= {mid, v_ff};
      end
   end

   always_comb begin
      top = (r_ff >= ROW_BITS'(2)) ? rd_ff[47:24] : '0;
      mid = (r_ff >= ROW_BITS'(1)) ? rd_ff[23:0]  : '0;
      for (int k = 0; k < 9; k++) begin
         base[k] = (c_ff == '0) ? '0 : win_ff[k];
      end
      for (int k = 0; k < 3; k++) begin
         nwin[k*3]     = base[k*3+1];
         nwin[k*3+1]   = base[k*3+2];
         ewin[k*3]     = win_ff[k*3+1];
         ewin[k*3+1]   = win_ff[k*3+2];
         ewin[k*3+2]   = '0;
      end
      nwin[2] = top;
      nwin[5] = mid;
      nwin[8] = v_ff;
      if (c_ff == '0) begin
         emit = (r_ff >= ROW_BITS'(2)) && ((r_ff - ROW_BITS'(2)) < h_eff);
         last = (r_ff - ROW_BITS'(2)) == (h_eff - HEIGHT_BITS'(1));
      end else begin
         for (int k = 0; k < 9; k++) begin
            ewin[k] = nwin[k];
         end
         emit = (r_ff >= ROW_BITS'(1)) && ((r_ff - ROW_BITS'(1)) < h_eff);
         last = 1'b0;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         gx_in[ch] = - $signed({3'b0, ewin[0][16-8*ch +: 8]})
                     + $signed({3'b0, ewin[2][16-8*ch +: 8]})
                     - $signed({2'b0, ewin[3][16-8*ch +: 8], 1'b0})
                     + $signed({2'b0, ewin[5][16-8*ch +: 8], 1'b0})
                     - $signed({3'b0, ewin[6][16-8*ch +: 8]})
                     + $signed({3'b0, ewin[8][16-8*ch +: 8]});
         gy_in[ch] = - $signed({3'b0, ewin[0][16-8*ch +: 8]})
                     - $signed({2'b0, ewin[1][16-8*ch +: 8], 1'b0})
                     - $signed({3'b0, ewin[2][16-8*ch +: 8]})
                     + $signed({3'b0, ewin[6][16-8*ch +: 8]})
                     + $signed({2'b0, ewin[7][16-8*ch +: 8], 1'b0})
                     + $signed({3'b0, ewin[8][16-8*ch +: 8]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (state_ff == ST_READ) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= nwin[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         for (int ch = 0; ch < 3; ch++) begin
            gx_ff[ch] <= gx_in[ch];
            gy_ff[ch] <= gy_in[ch];
         end
         last_ff <= last;
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_root
      logic signed [2*GRAD_BITS-1:0] px, py;
      logic        [2*GRAD_BITS-1:0] sum;
      assign px  = gx_ff[ch] * gx_ff[ch];
      assign py  = gy_ff[ch] * gy_ff[ch];
      assign sum = $unsigned(px) + $unsigned(py);
      assign rreq[ch].start  = (state_ff == ST_SQUARE);
      assign rreq[ch].square = sum[SQ_BITS-1:0];
      sem_root u_root (
         .clock (clock),
         .reset (reset),
         .req   (rreq[ch]),
         .rsp   (rrsp[ch])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_READ;
         ST_READ:   state_in = emit ? ST_SQUARE : ST_IDLE;
         ST_SQUARE: state_in = ST_ROOT;
         ST_ROOT:   if (rrsp[0].done && out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == ST_ROOT && rrsp[0].done && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_ROOT && rrsp[0].done && out_free) begin
         rsp_tdata_ff <= {rrsp[2].root, rrsp[1].root, rrsp[0].root};
         rsp_tlast_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_READ) else $error("accepted beat skipped line read");
   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && !emit) |=> state_ff == ST_IDLE)
      else $error("beat without result did not return to idle");
   a_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && rrsp[0].done && out_free) |=> rsp_tvalid_ff)
      else $error("finished result not presented");
   a_roots_lockstep: assert property (@(posedge clock) disable iff (reset)
      rrsp[0].done == rrsp[2].done) else $error("channel roots out of step");
endmodule
`default_nettype wire

// ===== bench/sobel_edge_magnitude_rgb_tb.sv =====
// Self-checking bench for the RGB Sobel edge magnitude block: raster frames in, magnitudes out.
`timescale 1ns / 100ps
module sobel_edge_magnitude_rgb_tb;
   import sem_pkg::*;

   localparam bit ACT_PIXEL   = 1'b0;
   localparam bit ACT_FLUSH   = 1'b1;
   localparam int WATCHDOG    = 5000;
   localparam int SETTLE      = 40;
   localparam int TOTAL_BEATS = 530;
   localparam int KX[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
   localparam int KY[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

   typedef struct {
      bit        flush;
      pixel_type rgb;
   } beat_t;

   typedef struct {
      pixel_type rgb;
      bit        last;
   } mag_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata = '0;  // red_in, green_in, blue_in
   logic                   req_tuser = 1'b0;  // action
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;  // red_out, green_out, blue_out
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_index = 1'b0;
   logic [HEIGHT_BITS-1:0] csr_data = '0;

   sobel_edge_magnitude_rgb dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   beat_t     pixel_q[$];
   mag_t      magnitude_q[$];
   beat_t     held;
   pixel_type upper_row[MAX_WIDTH];
   pixel_type middle_row[MAX_WIDTH];
   pixel_type win[9];
   int        col_pos = 0, row_pos = 0;
   int        cfg_width = RESET_WIDTH, cfg_height = RESET_HEIGHT;
   int        send_idle = 31, recv_idle = 66;
   int        beats_in = 0, results_ok = 0, mismatches = 0, frames = 0, quiet = 0;

   function automatic logic [7:0] rounded_root(input int s);
      int f, t;
      f = 0;
      if (s > ROOT_LIMIT) return 8'(CLAMP_LEVEL);
      for (int b = 128; b != 0; b >>= 1) begin
         t = f | b;
         if (t * t <= s) f = t;
      end
      if (s > f * f + f) f++;
      return 8'((f > CLAMP_LEVEL) ? CLAMP_LEVEL : f);
   endfunction

   function automatic mag_t magnitude(input pixel_type w[9], input bit last);
      mag_t m;
      int gx, gy, p;
      for (int ch = 0; ch < 3; ch++) begin
         gx = 0;
         gy = 0;
         for (int k = 0; k < 9; k++) begin
            p = w[k][8*ch +: 8];
            gx += p * KX[k];
            gy += p * KY[k];
         end
         m.rgb[8*ch +: 8] = rounded_root(gx * gx + gy * gy);
      end
      m.last = last;
      return m;
   endfunction

   function automatic void sobel_advance(input beat_t b);
      int w, h, c, r;
      pixel_type v, top, mid;
      pixel_type tmp[9];
      w = (cfg_width < 1) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
      h = (cfg_height < 1) ? 1 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      c = col_pos;
      r = row_pos;
      v = (b.flush || r >= h) ? '0 : b.rgb;
      if (c == 0) begin
         for (int k = 0; k < 3; k++) begin
            tmp[3*k]   = win[3*k+1];
            tmp[3*k+1] = win[3*k+2];
            tmp[3*k+2] = '0;
         end
         if (r >= 2 && r - 2 < h) magnitude_q.push_back(magnitude(tmp, r - 2 == h - 1));
         for (int k = 0; k < 9; k++) win[k] = '0;
      end
      top = (r >= 2) ? upper_row[c] : '0;
      mid = (r >= 1) ? middle_row[c] : '0;
      for (int k = 0; k < 3; k++) begin
         win[3*k]   = win[3*k+1];
         win[3*k+1] = win[3*k+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = v;
      upper_row[c] = mid;
      middle_row[c] = v;
      if (c >= 1 && r >= 1 && r - 1 < h) magnitude_q.push_back(magnitude(win, 1'b0));
      if (c == 0 && r >= h + 1) begin
         col_pos = 0;
         row_pos = 0;
      end else begin
         col_pos = c + 1;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sobel_advance(held);
            beats_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle) begin
               held = pixel_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= held.rgb;
               req_tuser <= held.flush;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      mag_t m;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (magnitude_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: rgb=%h last=%b", rsp_tdata, rsp_tlast);
            end else begin
               m = magnitude_q.pop_front();
               if (rsp_tdata !== m.rgb || rsp_tlast !== m.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected rgb=%h last=%b, got rgb=%h last=%b",
                              m.rgb, m.last, rsp_tdata, rsp_tlast);
               end else begin
                  results_ok++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet <= 0;
         else
            quiet <= quiet + 1;
         if (quiet == WATCHDOG) begin
            $display("sobel_edge_magnitude_rgb regression: fail");
            $finish;
         end
      end
   end

   task automatic drain();
      while (pixel_q.size() > 0 || req_tvalid || magnitude_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= HEIGHT_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) cfg_width = value & 11'h7FF;
      else cfg_height = value & 13'h1FFF;
   endtask

   task automatic add(input bit flush, input pixel_type rgb);
      beat_t b;
      b.flush = flush;
      b.rgb = rgb;
      pixel_q.push_back(b);
   endtask

   // queue one full frame plus its flush beats with random content
   task automatic random_frame(input int w_reg, input int h_reg);
      int w, h;
      drain();
      write_csr(CSR_IMAGE_WIDTH, w_reg);
      write_csr(CSR_IMAGE_HEIGHT, h_reg);
      w = (w_reg < 1) ? 1 : (w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg;
      h = (h_reg < 1) ? 1 : (h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg;
      @(negedge clock);
      for (int i = 0; i < w * h; i++)
         add($urandom_range(99) < 8 ? ACT_FLUSH : ACT_PIXEL, $urandom);
      for (int i = 0; i <= w; i++)
         add($urandom_range(99) < 15 ? ACT_PIXEL : ACT_FLUSH, $urandom);
      frames++;
   endtask

   initial begin
      int target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed 3x3 frame: extremes, flush inside frame, pixel during flush
      drain();
      write_csr(CSR_IMAGE_WIDTH, 3);
      write_csr(CSR_IMAGE_HEIGHT, 3);
      @(negedge clock);
      add(ACT_PIXEL, 24'hFFFFFF);
      add(ACT_PIXEL, 24'h000000);
      add(ACT_PIXEL, 24'hFFFFFF);
      add(ACT_PIXEL, 24'h000000);
      add(ACT_FLUSH, 24'hA5A5A5);
      add(ACT_PIXEL, 24'hFF00FF);
      add(ACT_PIXEL, 24'hFFFFFF);
      add(ACT_PIXEL, 24'h00FF00);
      add(ACT_PIXEL, 24'hFFFFFF);
      add(ACT_FLUSH, 24'h000000);
      add(ACT_PIXEL, 24'hFFFFFF);
      add(ACT_FLUSH, 24'h5A5A5A);
      add(ACT_FLUSH, 24'h000000);
      frames++;
      // zero width and height saturate to one
      drain();
      write_csr(CSR_IMAGE_WIDTH, 0);
      write_csr(CSR_IMAGE_HEIGHT, 0);
      @(negedge clock);
      add(ACT_PIXEL, 24'hFFFFFF);
      add(ACT_FLUSH, 24'h000000);
      add(ACT_PIXEL, 24'h123456);
      frames++;

      target = TOTAL_BEATS;
      while (beats_in + pixel_q.size() < target) begin
         if (beats_in > 200) begin
            send_idle = 66;
            recv_idle = 31;
         end
         if (beats_in > 400) begin
            send_idle = 0;
            recv_idle = 0;
         end
         if ($urandom_range(99) < 80)
            random_frame($urandom_range(1, 10), $urandom_range(1, 8));
         else
            random_frame($urandom_range(3, 40), $urandom_range(1, 4));
      end
      drain();

      $display("covered %0d frames, %0d input beats, %0d magnitudes matched",
               frames, beats_in, results_ok);
      $display("frame sizes from 1x1 up to 40 wide and 8 high, zero width and height saturated");
      if (mismatches == 0 && magnitude_q.size() == 0)
         $display("sobel_edge_magnitude_rgb regression: pass");
      else
         $display("sobel_edge_magnitude_rgb regression: fail");
      $finish;
   end
endmodule
